>>> sv/box_intersection_over_union_core_assert.svh
// Assertion macros for the box intersection over union core.
`ifndef BOX_INTERSECTION_OVER_UNION_CORE_ASSERT_SVH
`define BOX_INTERSECTION_OVER_UNION_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold on every clock edge out of reset.
`define BOXIOU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("boxiou assertion failed");

// Antecedent in one cycle implies the consequent in the next.
`define BOXIOU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("boxiou assertion failed");

`else

`define BOXIOU_ASSERT(lbl, prop)
`define BOXIOU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/boxiou_pkg.sv
// Types and constants shared by the box intersection over union core.
`timescale 1ns / 1ps

package boxiou_pkg;

    // Fraction bits of every normalized box field.
    localparam int FRAC_BITS = 16;

    localparam int EDGE_W = FRAC_BITS + 3;      // doubled edge, signed
    localparam int EXT_W  = FRAC_BITS + 1;      // doubled overlap extent
    localparam int PROD_W = 2 * EXT_W;          // intersection area
    localparam int AREA_W = 2 * FRAC_BITS;      // width * height, unscaled
    localparam int UNI_W  = 2 * FRAC_BITS + 3;  // union area (times four)
    localparam int REM_W  = UNI_W + 1;          // divider partial remainder
    localparam int QUO_W  = FRAC_BITS + 1;      // ratio, 1.0 included

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

    typedef struct packed {
        logic [FRAC_BITS-1:0] first_center_x;
        logic [FRAC_BITS-1:0] first_center_y;
        logic [FRAC_BITS-1:0] first_width;
        logic [FRAC_BITS-1:0] first_height;
        logic [FRAC_BITS-1:0] second_center_x;
        logic [FRAC_BITS-1:0] second_center_y;
        logic [FRAC_BITS-1:0] second_width;
        logic [FRAC_BITS-1:0] second_height;
    } box_pair_t;

    typedef struct packed {
        logic [QUO_W-1:0] overlap_ratio;
        logic             empty_union;
    } iou_result_t;

    // Word handed from cell to cell along the divider chain.
    typedef struct packed {
        logic             empty;
        logic [UNI_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_word_t;

endpackage

>>> sv/boxiou_front.sv
// Front pipeline: box edges, overlap extents, areas and union.
`timescale 1ns / 1ps

module boxiou_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  dims_zero,
    input  logic                  box_valid,
    output logic                  box_stall,
    input  boxiou_pkg::box_pair_t boxes,
    output logic                  dn_valid,
    input  logic                  dn_stall,
    output boxiou_pkg::div_word_t dn_word
);
    import boxiou_pkg::*;

    // Doubled overlap extent on one axis, clamped at zero.
    function automatic logic [EXT_W-1:0] extent(
        input logic signed [EDGE_W-1:0] a_lo,
        input logic signed [EDGE_W-1:0] a_hi,
        input logic signed [EDGE_W-1:0] b_lo,
        input logic signed [EDGE_W-1:0] b_hi
    );
        logic signed [EDGE_W-1:0] hi_min;
        logic signed [EDGE_W-1:0] lo_max;
        logic [EDGE_W:0]          d;
        hi_min = (a_hi < b_hi) ? a_hi : b_hi;
        lo_max = (a_lo > b_lo) ? a_lo : b_lo;
        d = {hi_min[EDGE_W-1], hi_min} - {lo_max[EDGE_W-1], lo_max};
        extent = d[EDGE_W] ? '0 : d[EXT_W-1:0];
    endfunction

    // Stage 1: doubled edges
    logic                     s1_valid_reg;
    logic                     s1_stall;
    logic signed [EDGE_W-1:0] s1_ax_lo_reg, s1_ax_hi_reg, s1_bx_lo_reg, s1_bx_hi_reg;
    logic signed [EDGE_W-1:0] s1_ay_lo_reg, s1_ay_hi_reg, s1_by_lo_reg, s1_by_hi_reg;
    logic [FRAC_BITS-1:0]     s1_aw_reg, s1_ah_reg, s1_bw_reg, s1_bh_reg;

    // Stage 2: overlap extents
    logic                 s2_valid_reg;
    logic                 s2_stall;
    logic [EXT_W-1:0]     s2_iw_reg, s2_ih_reg;
    logic [FRAC_BITS-1:0] s2_aw_reg, s2_ah_reg, s2_bw_reg, s2_bh_reg;

    // Stage 3: products
    logic              s3_valid_reg;
    logic              s3_stall;
    logic [PROD_W-1:0] s3_inter_reg;
    logic [AREA_W-1:0] s3_area_a_reg, s3_area_b_reg;

    // Stage 4: union, first divider word
    logic              s4_valid_reg;
    logic              s4_stall;
    div_word_t         s4_word_reg;
    div_word_t         s4_word_next;
    logic [UNI_W-1:0]  uni_next;

    assign s4_stall  = s4_valid_reg && dn_stall;
    assign s3_stall  = s3_valid_reg && s4_stall;
    assign s2_stall  = s2_valid_reg && s3_stall;
    assign s1_stall  = s1_valid_reg && s2_stall;
    assign box_stall = s1_stall;

    always_comb
    begin
        uni_next = UNI_W'({s3_area_a_reg, 2'b00}) + UNI_W'({s3_area_b_reg, 2'b00})
                 - UNI_W'(s3_inter_reg);
        s4_word_next.den   = uni_next;
        s4_word_next.rem   = REM_W'(s3_inter_reg);
        s4_word_next.quo   = '0;
        s4_word_next.empty = (uni_next == '0) || dims_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_stall)
                s1_valid_reg <= box_valid;
            if (!s2_stall)
                s2_valid_reg <= s1_valid_reg;
            if (!s3_stall)
                s3_valid_reg <= s2_valid_reg;
            if (!s4_stall)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_valid && !s1_stall)
        begin
            s1_ax_lo_reg <= $signed({2'b00, boxes.first_center_x, 1'b0})
                          - $signed({3'b000, boxes.first_width});
            s1_ax_hi_reg <= $signed({2'b00, boxes.first_center_x, 1'b0})
                          + $signed({3'b000, boxes.first_width});
            s1_bx_lo_reg <= $signed({2'b00, boxes.second_center_x, 1'b0})
                          - $signed({3'b000, boxes.second_width});
            s1_bx_hi_reg <= $signed({2'b00, boxes.second_center_x, 1'b0})
                          + $signed({3'b000, boxes.second_width});
            s1_ay_lo_reg <= $signed({2'b00, boxes.first_center_y, 1'b0})
                          - $signed({3'b000, boxes.first_height});
            s1_ay_hi_reg <= $signed({2'b00, boxes.first_center_y, 1'b0})
                          + $signed({3'b000, boxes.first_height});
            s1_by_lo_reg <= $signed({2'b00, boxes.second_center_y, 1'b0})
                          - $signed({3'b000, boxes.second_height});
            s1_by_hi_reg <= $signed({2'b00, boxes.second_center_y, 1'b0})
                          + $signed({3'b000, boxes.second_height});
            s1_aw_reg <= boxes.first_width;
            s1_ah_reg <= boxes.first_height;
            s1_bw_reg <= boxes.second_width;
            s1_bh_reg <= boxes.second_height;
        end
        if (s1_valid_reg && !s2_stall)
        begin
            s2_iw_reg <= extent(s1_ax_lo_reg, s1_ax_hi_reg, s1_bx_lo_reg, s1_bx_hi_reg);
            s2_ih_reg <= extent(s1_ay_lo_reg, s1_ay_hi_reg, s1_by_lo_reg, s1_by_hi_reg);
            s2_aw_reg <= s1_aw_reg;
            s2_ah_reg <= s1_ah_reg;
            s2_bw_reg <= s1_bw_reg;
            s2_bh_reg <= s1_bh_reg;
        end
        if (s2_valid_reg && !s3_stall)
        begin
            s3_inter_reg  <= s2_iw_reg * s2_ih_reg;
            s3_area_a_reg <= s2_aw_reg * s2_ah_reg;
            s3_area_b_reg <= s2_bw_reg * s2_bh_reg;
        end
        if (s3_valid_reg && !s4_stall)
            s4_word_reg <= s4_word_next;
    end

    assign dn_valid = s4_valid_reg;
    assign dn_word  = s4_word_reg;

endmodule

>>> sv/boxiou_div_cell.sv
// One restoring division step of the fractional divider chain.
`timescale 1ns / 1ps
`include "box_intersection_over_union_core_assert.svh"

module boxiou_div_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_stall,
    input  boxiou_pkg::div_word_t up_word,
    output logic                  dn_valid,
    input  logic                  dn_stall,
    output boxiou_pkg::div_word_t dn_word
);
    import boxiou_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    div_word_t        word_reg;
    div_word_t        word_next;
    logic             take;
    logic [REM_W-1:0] diff;

    assign up_stall = valid_reg && dn_stall;

    always_comb
    begin
        valid_next = up_stall ? valid_reg : up_valid;
        // Compare, subtract, then shift the remainder for the next cell.
        take = up_word.rem >= {1'b0, up_word.den};
        diff = up_word.rem - (take ? {1'b0, up_word.den} : '0);
        word_next.empty = up_word.empty;
        word_next.den   = up_word.den;
        word_next.rem   = {diff[REM_W-2:0], 1'b0};
        word_next.quo   = {up_word.quo[QUO_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    // Remainder stays below the divisor after every step.
    `BOXIOU_ASSERT(a_rem_bound, !valid_reg || word_reg.empty || (word_reg.rem[REM_W-1:1] < word_reg.den))
    // A held word does not move while the next cell stalls.
    `BOXIOU_ASSERT_NEXT(a_hold, valid_reg && dn_stall, valid_reg && $stable(word_reg))
    // A transfer in always lands in this cell.
    `BOXIOU_ASSERT_NEXT(a_take, up_valid && !up_stall, valid_reg)

endmodule

>>> sv/box_intersection_over_union_core.sv
// Top level of the box intersection over union core.
`timescale 1ns / 1ps

// Takes one pair of center-format boxes (normalized Q0.16) per cycle while
// box_stall is low and returns their intersection over union as unsigned
// Q1.16, 65536 meaning exactly one, truncated. The path is four front
// stages (edges, overlap extents, area multipliers, union) and a chain of 17
// divider cells, one quotient bit per cell. A new pair is taken every cycle;
// result_stall holds the chain and ripples back only through occupied stages,
// so empty stages keep filling. The image size registers only matter when
// zero: the pixel scale cancels in the ratio. A zero union or zero image size
// gives a ratio of 0 with empty_union set. Write the registers only while idle.
module box_intersection_over_union_core
#(
    parameter int DIM_BITS = 13
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       write_enable,
    input  logic [boxiou_pkg::CFG_INDEX_W-1:0]         reg_index,
    input  logic [DIM_BITS-1:0]                        write_data,
    input  logic                                       box_valid,
    output logic                                       box_stall,
    input  boxiou_pkg::box_pair_t                      boxes,
    output logic                                       result_valid,
    input  logic                                       result_stall,
    output boxiou_pkg::iou_result_t                    result
);
    import boxiou_pkg::*;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(IMAGE_WIDTH_RESET);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(IMAGE_HEIGHT_RESET);

    logic [DIM_BITS-1:0] image_width_reg;
    logic [DIM_BITS-1:0] image_height_reg;
    logic                dims_zero;

    // Index 0 is the front output, index QUO_W the last cell.
    logic      chain_valid [QUO_W+1];
    logic      chain_stall [QUO_W+1];
    div_word_t chain_word  [QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (write_enable)
        begin
            case (reg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= write_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= write_data;
                default: ;
            endcase
        end
    end

    assign dims_zero = (image_width_reg == '0) || (image_height_reg == '0);

    boxiou_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims_zero (dims_zero),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .boxes     (boxes),
        .dn_valid  (chain_valid[0]),
        .dn_stall  (chain_stall[0]),
        .dn_word   (chain_word[0])
    );

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        boxiou_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_stall (chain_stall[i]),
            .up_word  (chain_word[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_stall (chain_stall[i+1]),
            .dn_word  (chain_word[i+1])
        );
    end

    assign chain_stall[QUO_W] = result_stall;
    assign result_valid       = chain_valid[QUO_W];

    always_comb
    begin
        result.empty_union   = chain_word[QUO_W].empty;
        result.overlap_ratio = chain_word[QUO_W].empty ? '0 : chain_word[QUO_W].quo;
    end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the box intersection over union core.
`timescale 1ns / 1ps

module tb;

    import boxiou_pkg::*;

    localparam int DIM_W          = 13;
    localparam int LATENCY        = 21;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    logic              clk;
    logic              rst_n;
    logic              write_enable;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [DIM_W-1:0]  write_data;
    logic              box_valid;
    logic              box_stall;
    box_pair_t         boxes;
    logic              result_valid;
    logic              result_stall;
    iou_result_t       result;

    box_intersection_over_union_core #(.DIM_BITS(DIM_W)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .box_valid    (box_valid),
        .box_stall    (box_stall),
        .boxes        (boxes),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    box_pair_t   pending_pairs[$];
    iou_result_t expected_iou[$];

    logic [DIM_W-1:0] image_width_copy;
    logic [DIM_W-1:0] image_height_copy;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;

    int pairs_sent;
    int results_seen;
    int empty_seen;
    int unity_seen;
    int mismatch_count;
    int settings_used;
    iou_result_t want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Doubled overlap extent along one axis, clamped at zero.
    function automatic longint axis_overlap(logic [FRAC_BITS-1:0] ca, logic [FRAC_BITS-1:0] sa,
                                            logic [FRAC_BITS-1:0] cb, logic [FRAC_BITS-1:0] sb);
        longint a_lo;
        longint a_hi;
        longint b_lo;
        longint b_hi;
        longint d;
        a_lo = 2 * longint'(ca) - longint'(sa);
        a_hi = 2 * longint'(ca) + longint'(sa);
        b_lo = 2 * longint'(cb) - longint'(sb);
        b_hi = 2 * longint'(cb) + longint'(sb);
        d = ((a_hi < b_hi) ? a_hi : b_hi) - ((a_lo > b_lo) ? a_lo : b_lo);
        return (d < 0) ? 0 : d;
    endfunction

    function automatic iou_result_t predict_iou(box_pair_t p);
        longint inter;
        longint area_a;
        longint area_b;
        longint uni;
        longint ratio;
        iou_result_t r;
        inter = axis_overlap(p.first_center_x, p.first_width, p.second_center_x, p.second_width)
              * axis_overlap(p.first_center_y, p.first_height, p.second_center_y, p.second_height);
        area_a = 4 * longint'(p.first_width) * longint'(p.first_height);
        area_b = 4 * longint'(p.second_width) * longint'(p.second_height);
        uni = area_a + area_b - inter;
        // pixel scale cancels; only a zero dimension matters
        if (uni == 0 || image_width_copy == '0 || image_height_copy == '0)
        begin
            r.overlap_ratio = '0;
            r.empty_union   = 1'b1;
        end
        else
        begin
            ratio = (inter << FRAC_BITS) / uni;
            r.overlap_ratio = ratio[QUO_W-1:0];
            r.empty_union   = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [FRAC_BITS-1:0] jitter(logic [FRAC_BITS-1:0] v, int span);
        int t;
        t = int'(v) + int'($urandom_range(2 * span)) - span;
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        return t[FRAC_BITS-1:0];
    endfunction

    function automatic box_pair_t random_pair();
        box_pair_t p;
        int kind;
        int span;
        p = {$urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(99);
        span = 1 << $urandom_range(15, 4);
        if (kind < 20)
        begin
            // fully random fields
        end
        else if (kind < 60)
        begin
            // nearby boxes of similar size: the usual tracking case
            p.first_width      = FRAC_BITS'($urandom_range(span - 1));
            p.first_height     = FRAC_BITS'($urandom_range(span - 1));
            p.second_center_x  = jitter(p.first_center_x, span / 2);
            p.second_center_y  = jitter(p.first_center_y, span / 2);
            p.second_width     = jitter(p.first_width, span / 4);
            p.second_height    = jitter(p.first_height, span / 4);
        end
        else if (kind < 72)
        begin
            p.second_center_x = p.first_center_x;
            p.second_center_y = p.first_center_y;
            p.second_width    = p.first_width;
            p.second_height   = p.first_height;
        end
        else if (kind < 82)
        begin
            // degenerate sizes on one or both boxes
            if ($urandom_range(1))
                p.first_width = '0;
            else
                p.first_height = '0;
            if ($urandom_range(1))
                p.second_width = '0;
        end
        else
        begin
            p.first_width   = FRAC_BITS'($urandom_range(span - 1));
            p.first_height  = FRAC_BITS'($urandom_range(span - 1));
            p.second_width  = FRAC_BITS'($urandom_range(span - 1));
            p.second_height = FRAC_BITS'($urandom_range(span - 1));
        end
        return p;
    endfunction

    // Configuration mirror follows the write port exactly.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_copy  <= DIM_W'(IMAGE_WIDTH_RESET);
            image_height_copy <= DIM_W'(IMAGE_HEIGHT_RESET);
        end
        else if (write_enable)
        begin
            if (reg_index == CFG_IMAGE_WIDTH)
                image_width_copy <= write_data;
            else if (reg_index == CFG_IMAGE_HEIGHT)
                image_height_copy <= write_data;
        end
    end

    // Box pair driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid <= 1'b0;
            boxes     <= '0;
        end
        else
        begin
            if (box_valid && !box_stall)
            begin
                expected_iou.push_back(predict_iou(boxes));
                pairs_sent++;
            end
            if (!box_valid || !box_stall)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    boxes     <= pending_pairs.pop_front();
                    box_valid <= 1'b1;
                end
                else
                    box_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (result.empty_union)
                    empty_seen++;
                if (result.overlap_ratio == QUO_W'(1 << FRAC_BITS))
                    unity_seen++;
                if (expected_iou.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result ratio=%h empty=%b",
                                 $realtime, result.overlap_ratio, result.empty_union);
                end
                else
                begin
                    want = expected_iou.pop_front();
                    if (result.overlap_ratio !== want.overlap_ratio ||
                        result.empty_union !== want.empty_union)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch ratio exp=%h got=%h, empty exp=%b got=%b",
                                     $realtime, want.overlap_ratio, result.overlap_ratio,
                                     want.empty_union, result.empty_union);
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((box_valid && !box_stall) || (result_valid && !result_stall) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_iou.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pending_pairs.size() != 0 || box_valid || expected_iou.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 3) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [DIM_W-1:0] value);
        @(posedge clk);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= value;
        @(posedge clk);
        write_enable <= 1'b0;
    endtask

    task automatic push_random(int count);
        repeat (count) pending_pairs.push_back(random_pair());
    endtask

    task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        settings_used++;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        write_enable   = 1'b0;
        reg_index      = CFG_IMAGE_WIDTH;
        write_data     = '0;
        send_idle_pct  = 25;
        recv_idle_pct  = 62;
        hold_requests  = 0;
        hold_served    = 0;
        pairs_sent     = 0;
        results_seen   = 0;
        empty_seen     = 0;
        unity_seen     = 0;
        mismatch_count = 0;
        settings_used  = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed pairs under the reset image size
        pending_pairs.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000});
        pending_pairs.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_pairs.push_back('{16'h8000, 16'h8000, 16'h4000, 16'h4000,
                                  16'h8000, 16'h8000, 16'h4000, 16'h4000});
        pending_pairs.push_back('{16'h8000, 16'h8000, 16'h0000, 16'h0000,
                                  16'h8000, 16'h8000, 16'h4000, 16'h4000});
        pending_pairs.push_back('{16'h8000, 16'h8000, 16'h0000, 16'h4000,
                                  16'h8000, 16'h8000, 16'h2000, 16'h0000});
        pending_pairs.push_back('{16'h2000, 16'h2000, 16'h1000, 16'h1000,
                                  16'hC000, 16'hC000, 16'h1000, 16'h1000});
        // edges touching exactly along x
        pending_pairs.push_back('{16'h4000, 16'h8000, 16'h2000, 16'h2000,
                                  16'h6000, 16'h8000, 16'h2000, 16'h2000});
        // boxes reaching past the image border on both sides
        pending_pairs.push_back('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_pairs.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h2000, 16'h2000});
        pending_pairs.push_back('{16'h4000, 16'h8000, 16'h4000, 16'h4000,
                                  16'h6000, 16'h8000, 16'h4000, 16'h4000});
        pending_pairs.push_back('{16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001,
                                  16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001});
        pending_pairs.push_back('{16'h8000, 16'h8000, 16'h0003, 16'h0003,
                                  16'h8001, 16'h8000, 16'h0003, 16'h0003});
        pending_pairs.push_back('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                  16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        pending_pairs.push_back('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                                  16'h0000, 16'h0000, 16'h0001, 16'h0001});
        pending_pairs.push_back('{16'h4000, 16'h4000, 16'h8000, 16'h0000,
                                  16'h4000, 16'h4000, 16'h8000, 16'h0000});
        pending_pairs.push_back('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                  16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        push_random(120);
        wait_drained();

        send_idle_pct = 62;
        recv_idle_pct = 25;
        set_dims(DIM_W'(8191), DIM_W'(1));
        push_random(120);
        wait_drained();

        // zero image size forces every result to an empty union
        set_dims(DIM_W'(0), DIM_W'(480));
        push_random(15);
        wait_drained();
        set_dims(DIM_W'(1), DIM_W'(0));
        push_random(15);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_dims(DIM_W'($urandom_range(8191, 1)), DIM_W'(8191));
        // long receiver hold while pairs keep coming: fills the pipe
        hold_requests++;
        push_random(60);
        wait_drained();
        push_random(60);
        wait_drained();

        $display("covered %0d box pairs over %0d image size settings", pairs_sent, settings_used);
        $display("results: %0d checked, %0d empty union, %0d exact overlap, %0d mismatches",
                 results_seen, empty_seen, unity_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
